// ===== rtl/core/lnr_pkg.sv =====
// ----------------------------------------------------------------------------
// lnr_pkg: shared constants and types for the row layer normaliser
// Widths of the row store, the serial divider and the link between them.
// ----------------------------------------------------------------------------
`default_nettype none
package lnr_pkg;

  localparam int MAX_ROW   = 64;
  localparam int ADDR_W    = $clog2(MAX_ROW);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int DATA_W    = 16;
  localparam int CFG_W     = 7;
  localparam logic [CFG_W-1:0] ROW_LEN_RESET = CFG_W'(MAX_ROW);
  localparam int SUM_W     = 23;
  localparam int STORE_W   = 3 * DATA_W;

  // serial divider: dividend is left aligned, quotient ends in the low bits
  localparam int DIV_W     = 39;
  localparam int DSR_W     = 16;
  localparam int STEP_W    = 6;
  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(22);
  localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(39);
  localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(24);

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/lnr_in_if.sv =====
// ----------------------------------------------------------------------------
// lnr_in_if: input element channel
// One transaction carries a sample with the gain and offset of its channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface lnr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic signed [15:0] gain;
  logic signed [15:0] offset;

  modport source(output valid, sample, gain, offset, input ready);
  modport sink(input valid, sample, gain, offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lnr_out_if.sv =====
// ----------------------------------------------------------------------------
// lnr_out_if: normalised result channel
// One transaction carries one result with its channel index and row end flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface lnr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result;
  logic [5:0]         position;
  logic               last;

  modport source(output valid, result, position, last, input ready);
  modport sink(input valid, result, position, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lnr_ram.sv =====
// ----------------------------------------------------------------------------
// lnr_ram: generic single write, single read RAM
// Registered read data: rdata shows the word at raddr in the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none
module lnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/lnr_div.sv =====
// ----------------------------------------------------------------------------
// lnr_div: restoring serial divider, one quotient bit per cycle
// Unsigned; the caller aligns the dividend to the top and picks the step count.
// ----------------------------------------------------------------------------
`default_nettype none
module lnr_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lnr_pkg::div_req_t req,
  output lnr_pkg::div_rsp_t      rsp
);
  import lnr_pkg::*;

  logic [DIV_W-1:0]  dq;
  logic [DSR_W-1:0]  rem;
  logic [DSR_W-1:0]  dsr;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DSR_W:0]    trial;
  logic              ge;

  assign trial = {rem, dq[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= req.steps;
        dq   <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem  <= ge ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
        dq   <= {dq[DIV_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        done <= (cnt == STEP_W'(1));
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dq;
endmodule
`default_nettype wire

// ===== rtl/core/layer_norm_row.sv =====
// ----------------------------------------------------------------------------
// layer_norm_row: layer normalisation over one row of channels
// Buffers a row, then emits ((x - mean) / std) * gain + offset per channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - one transaction per channel element: Q8.8 sample, gain, offset.
//   out_ch - one transaction per channel of a finished row, in channel order,
//            with position and a last flag on the final channel.
//   cfg_we / cfg_wdata - row_length (1..64); write only while the block idles.
// An element that does not complete a row is stored and gives nothing.
// The element that completes a row of n starts the row computation:
//   mean division, variance pass (read, square, accumulate per channel),
//   variance division, square root, then per channel a read, a 24-step
//   divide, a multiply and the output step; a flat row skips the divide.
//   The serial divider is shared by the mean, the variance and every
//   normalised value of a row that is not flat.
// in_ch.ready stays low while the row is computed, until the last result
// is loaded into the output register.
// Reset clears the row fill count, the running sum and the output valid flag,
// and loads row_length with 64. The row store needs no clearing.
// When out_ch stalls, the result register holds and the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none
module layer_norm_row (
  input  wire logic                       clk,
  input  wire logic                       rst,
  lnr_in_if.sink                          in_ch,
  lnr_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [lnr_pkg::CFG_W-1:0]  cfg_wdata
);
  import lnr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN_GO, S_MEAN_WAIT, S_VAR_RD, S_VAR_SQ, S_VAR_ACC,
    S_VDIV_GO, S_VDIV_WAIT, S_SQRT, S_EL_RD, S_EL_D, S_EL_DIV, S_EL_MUL,
    S_EL_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0]        row_length;
  logic [CNT_W-1:0]        fill_count;
  logic signed [SUM_W-1:0] running_sum;
  logic [CNT_W-1:0]        n;
  logic [ADDR_W-1:0]       j;
  logic signed [DATA_W-1:0] mean;
  logic [DIV_W-1:0]        vsum;
  logic [31:0]             sq_v;
  logic [17:0]             sq_rem;
  logic [15:0]             sq_root;
  logic [4:0]              sq_cnt;
  logic signed [16:0]      d;
  logic signed [DATA_W-1:0] gain_r;
  logic signed [DATA_W-1:0] offset_r;
  logic signed [24:0]      norm;
  logic signed [41:0]      prod;

  logic                    out_valid;
  logic signed [DATA_W-1:0] out_result;
  logic [ADDR_W-1:0]       out_position;
  logic                    out_last;

  // element store
  logic [STORE_W-1:0]      rdata;
  logic [ADDR_W-1:0]       raddr;
  logic [ADDR_W-1:0]       widx;
  logic                    in_acc;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic [CFG_W-1:0]        len_eff;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [DATA_W-1:0] rd_sample;
  logic signed [16:0]      d_now;
  logic [15:0]             d_mag;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [24:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [41:0]      mul_p;
  logic signed [41:0]      prod_adj;
  logic signed [33:0]      scaled;
  logic signed [34:0]      y_full;
  logic signed [DATA_W-1:0] y_sat;
  logic [19:0]             sq_t;
  logic [19:0]             sq_trial;
  logic                    sq_ge;
  logic                    row_end;
  logic                    out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // Clamp the configured length into 1..MAX_ROW.
  always_comb begin
    priority if (row_length == '0) begin
      len_eff = CFG_W'(1);
    end else if (row_length > CFG_W'(MAX_ROW)) begin
      len_eff = CFG_W'(MAX_ROW);
    end else begin
      len_eff = row_length;
    end
  end

  assign widx    = (fill_count >= CNT_W'(MAX_ROW)) ? ADDR_W'(MAX_ROW - 1)
                                                   : fill_count[ADDR_W-1:0];
  assign count   = {1'b0, widx} + CNT_W'(1);
  assign sum_new = running_sum + SUM_W'(in_ch.sample);
  assign raddr   = j;

  lnr_ram #(.WIDTH(STORE_W), .DEPTH(MAX_ROW)) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (widx),
    .wdata ({in_ch.sample, in_ch.gain, in_ch.offset}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_sample = rdata[STORE_W-1 -: DATA_W];
  assign d_now     = 17'(rd_sample) - 17'(mean);
  assign d_mag     = d_now[16] ? 16'(-d_now) : d_now[15:0];
  assign sum_mag   = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : running_sum;

  // Divider requests: mean, variance, per-channel normalisation.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.steps    = MEAN_STEPS;
    div_req.dividend = {sum_mag[21:0], 17'b0};
    div_req.divisor  = DSR_W'(n);
    unique case (state)
      S_MEAN_GO: div_req.start = 1'b1;
      S_VDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = VAR_STEPS;
        div_req.dividend = vsum;
      end
      S_EL_D: begin
        div_req.start    = (sq_root != '0);
        div_req.steps    = NORM_STEPS;
        div_req.dividend = {d_mag, 8'b0, 15'b0};
        div_req.divisor  = sq_root;
      end
      default: ;
    endcase
  end

  lnr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // One multiplier: squares in the variance pass, norm * gain per channel.
  always_comb begin
    if (state == S_VAR_SQ) begin
      mul_a = 25'(d_now);
      mul_b = d_now;
    end else begin
      mul_a = norm;
      mul_b = 17'(gain_r);
    end
  end
  assign mul_p = 42'(mul_a) * 42'(mul_b);

  // Truncate toward zero on the /256, add the offset, saturate.
  assign prod_adj = prod + (prod[41] ? 42'sd255 : 42'sd0);
  assign scaled   = 34'(prod_adj >>> 8);
  assign y_full   = 35'(scaled) + 35'(offset_r);
  always_comb begin
    priority if (y_full > 35'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (y_full < -35'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_full[DATA_W-1:0];
    end
  end

  // Square root, two radicand bits per step.
  assign sq_t     = {sq_rem, sq_v[31:30]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  assign row_end  = ({1'b0, j} == n - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      row_length  <= ROW_LEN_RESET;
      fill_count  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_length <= cfg_wdata;
      end
      // drop the result once taken, unless the output step reloads it
      if (out_valid && out_ch.ready && (state != S_EL_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            running_sum <= sum_new;
            if ({1'b0, count} < {1'b0, len_eff}) begin
              fill_count <= count;
            end else begin
              n     <= count;
              state <= S_MEAN_GO;
            end
          end
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean  <= running_sum[SUM_W-1] ? DATA_W'(-div_rsp.quotient[21:0])
                                          : DATA_W'(div_rsp.quotient[21:0]);
            j     <= '0;
            vsum  <= '0;
            state <= S_VAR_RD;
          end
        end
        S_VAR_RD: state <= S_VAR_SQ;
        S_VAR_SQ: begin
          prod  <= mul_p;
          state <= S_VAR_ACC;
        end
        S_VAR_ACC: begin
          vsum <= vsum + DIV_W'(prod[31:0]);
          if (row_end) begin
            state <= S_VDIV_GO;
          end else begin
            j     <= j + 1'b1;
            state <= S_VAR_RD;
          end
        end
        S_VDIV_GO: state <= S_VDIV_WAIT;
        S_VDIV_WAIT: begin
          if (div_rsp.done) begin
            sq_v    <= div_rsp.quotient[31:0];
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_v    <= {sq_v[29:0], 2'b00};
          sq_rem  <= sq_ge ? 18'(sq_t - sq_trial) : sq_t[17:0];
          sq_root <= {sq_root[14:0], sq_ge};
          sq_cnt  <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd15) begin
            j     <= '0;
            state <= S_EL_RD;
          end
        end
        S_EL_RD: state <= S_EL_D;
        S_EL_D: begin
          d        <= d_now;
          gain_r   <= rdata[DATA_W +: DATA_W];
          offset_r <= rdata[DATA_W-1:0];
          if (sq_root == '0) begin
            norm  <= '0;
            state <= S_EL_MUL;
          end else begin
            state <= S_EL_DIV;
          end
        end
        S_EL_DIV: begin
          if (div_rsp.done) begin
            norm  <= d[16] ? -{1'b0, div_rsp.quotient[23:0]}
                           : {1'b0, div_rsp.quotient[23:0]};
            state <= S_EL_MUL;
          end
        end
        S_EL_MUL: begin
          prod  <= mul_p;
          state <= S_EL_OUT;
        end
        S_EL_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_result   <= y_sat;
            out_position <= j;
            out_last     <= row_end;
            if (row_end) begin
              fill_count  <= '0;
              running_sum <= '0;
              state       <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_EL_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.result   = out_result;
  assign out_ch.position = out_position;
  assign out_ch.last     = out_last;

  // Never restart the divider while a division is running.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // A partial row never fills the store.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count < CNT_W'(MAX_ROW))
    else $error("fill count out of range");

  // The last result of a row hands control back to the input side.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EL_OUT && out_free && row_end) |=> (state == S_IDLE))
    else $error("row end did not return to idle");

  // A result is only loaded into the output register from the output step.
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EL_OUT))
    else $error("result loaded outside output step");
endmodule
`default_nettype wire

// ===== dv/layer_norm_row_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_norm_row_test: self-checking bench for the row layer normaliser
// Drives rows of Q8.8 elements under random idling on both channels, predicts
// every normalised result in fixed point and checks each output transaction
// in order. Row length is changed between phases, with its corner values.
// ----------------------------------------------------------------------------
module layer_norm_row_test;
  import lnr_pkg::*;

  typedef struct packed {
    logic signed [15:0] result;
    logic [5:0]         position;
    logic               last;
  } norm_out_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lnr_in_if  in_ch();
  lnr_out_if out_ch();

  layer_norm_row u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: a private copy of the row store and the register.
  logic [CFG_W-1:0]   pred_row_len;
  logic signed [15:0] pred_sample [MAX_ROW];
  logic signed [15:0] pred_gain   [MAX_ROW];
  logic signed [15:0] pred_offset [MAX_ROW];
  int                 pred_fill;
  longint             pred_sum;

  norm_out_t pending_results[$];
  int  errors;
  int  items_sent;
  int  results_seen;
  int  rows_closed;
  int  hold_off;     // long receiver stall, counted down by the sink process
  bit  quiet;        // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous fixed limit on the whole run.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Store one accepted element; when it closes the row, queue the whole row
  // of normalised results in channel order.
  function automatic void predict_norm_row(logic signed [15:0] s, logic signed [15:0] g,
                                           logic signed [15:0] o);
    int len;
    int idx;
    int cnt;
    longint mean;
    longint var_sum;
    longint dev;
    longint norm;
    longint y;
    longint unsigned std_dev;
    norm_out_t r;
    len = (pred_row_len == 0) ? 1 : ((pred_row_len > MAX_ROW) ? MAX_ROW : pred_row_len);
    idx = (pred_fill >= MAX_ROW) ? MAX_ROW - 1 : pred_fill;
    pred_sample[idx] = s;
    pred_gain[idx]   = g;
    pred_offset[idx] = o;
    pred_sum = pred_sum + s;
    cnt = idx + 1;
    if (cnt < len) begin
      pred_fill = cnt;
      return;
    end
    mean = pred_sum / cnt;
    var_sum = 0;
    for (int j = 0; j < cnt; j++) begin
      dev = longint'(pred_sample[j]) - mean;
      var_sum += dev * dev;
    end
    std_dev = floor_root(longint'(var_sum / cnt));
    for (int j = 0; j < cnt; j++) begin
      dev  = longint'(pred_sample[j]) - mean;
      // flat row: zero deviation leaves only the offset
      norm = (std_dev == 0) ? 0 : (dev * 256) / longint'(std_dev);
      y = (norm * longint'(pred_gain[j])) / 256 + longint'(pred_offset[j]);
      if (y > 32767)  y = 32767;
      if (y < -32768) y = -32768;
      r.result   = y[15:0];
      r.position = j[5:0];
      r.last     = (j + 1 == cnt);
      pending_results.push_back(r);
    end
    rows_closed++;
    pred_fill = 0;
    pred_sum  = 0;
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return $urandom_range(1, 3);
      4:          return $urandom_range(15, 60);
      default:    return 0;
    endcase
  endfunction

  // Offer one element after a random gap; hold valid across back-to-back
  // transactions so it never drops and rises within one step.
  task automatic send_element(logic signed [15:0] s, logic signed [15:0] g,
                              logic signed [15:0] o);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.gain   <= g;
    in_ch.offset <= o;
    do @(posedge clk); while (!in_ch.ready);
    predict_norm_row(s, g, o);
    items_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every expected result, then let any trailing work settle.
  task automatic wait_idle();
    stop_sending();
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_row_length(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_row_len = v;
  endtask

  function automatic logic signed [15:0] rand_word();
    // mostly moderate values so the normalised output carries information
    case ($urandom_range(0, 3))
      0:       return 16'($urandom());
      1:       return 16'sd1 << $urandom_range(0, 15);
      default: return 16'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic send_random_row(int n);
    for (int i = 0; i < n; i++)
      send_element(rand_word(), rand_word(), rand_word());
  endtask

  // Check every output transaction against the oldest prediction; also
  // drive the receiver's idling and the long hold-off.
  initial begin : result_checker
    norm_out_t want;
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %0d pos %0d last %0b", $time,
                   out_ch.result, out_ch.position, out_ch.last);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.result !== want.result) begin
            errors++;
            $display("%0t: result expected %0d actual %0d (pos %0d)", $time,
                     want.result, out_ch.result, want.position);
          end
          if (out_ch.position !== want.position) begin
            errors++;
            $display("%0t: position expected %0d actual %0d", $time,
                     want.position, out_ch.position);
          end
          if (out_ch.last !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_ch.last);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3: stall_left = $urandom_range(1, 3);
            4:          stall_left = $urandom_range(15, 60);
            default:    stall_left = 0;
          endcase
        end
      end
    end
  end

  // Extreme fields: flat rows, saturation both ways, extreme offsets.
  task automatic test_field_extremes();
    write_row_length(7'd4);
    // flat row: zero deviation, results are the offsets
    send_element(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_element(16'sh7FFF, -16'sh8000, -16'sh8000);
    send_element(16'sh7FFF, 16'sh0100, 16'sh0000);
    send_element(16'sh7FFF, 16'sh0000, 16'shFFFF);
    // full swing with extreme gains: saturates high and low
    send_element(-16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_element(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_element(-16'sh8000, -16'sh8000, -16'sh8000);
    send_element(16'sh7FFF, -16'sh8000, -16'sh8000);
    wait_idle();
  endtask

  // Row length corners: one, zero (as one), two, lowered mid-row.
  task automatic test_row_lengths();
    write_row_length(7'd1);
    send_element(16'sh1234, 16'sh0100, 16'sh0055);
    wait_idle();
    write_row_length(7'd0);
    send_element(-16'sh0400, 16'sh7FFF, -16'sh0100);
    wait_idle();
    write_row_length(7'd2);
    send_element(16'sh0100, 16'sh0100, 16'sh0000);
    send_element(16'sh0300, 16'sh0100, 16'sh0000);
    wait_idle();
    // lower the length while three elements sit in the row: next one closes it
    write_row_length(7'd8);
    send_random_row(3);
    wait_idle();
    write_row_length(7'd2);
    send_element(16'sh0080, 16'sh0200, 16'sh0010);
    wait_idle();
  endtask

  // Full row through the above-maximum setting, then random short rows.
  task automatic test_random_rows();
    int n;
    write_row_length(7'h7F);
    quiet = 1'b1;
    send_random_row(32);
    quiet = 1'b0;
    send_random_row(32);
    wait_idle();
    while (items_sent < 100) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      write_row_length(n[CFG_W-1:0]);
      send_random_row(n);
      wait_idle();
    end
  endtask

  // Hold the receiver off while rows keep coming, so the block stalls its input.
  task automatic test_output_hold();
    write_row_length(7'd3);
    hold_off = 3000;
    send_random_row(9);
    wait_idle();
    write_row_length(7'd64);
  endtask

  initial begin
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    rows_closed  = 0;
    hold_off     = 0;
    quiet        = 1'b0;
    pred_row_len = ROW_LEN_RESET;
    pred_fill    = 0;
    pred_sum     = 0;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.gain   <= '0;
    in_ch.offset <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_row_lengths();
    test_random_rows();
    test_output_hold();

    $display("covered %0d elements in %0d rows, %0d results checked,", items_sent,
             rows_closed, results_seen);
    $display("row lengths 0 to 127, flat rows, saturation, mid-row shortening, long stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lnr_pkg.sv
rtl/core/lnr_in_if.sv
rtl/core/lnr_out_if.sv
rtl/core/lnr_ram.sv
rtl/core/lnr_div.sv
rtl/core/layer_norm_row.sv
dv/layer_norm_row_test.sv
